FILE: rtl/core/bcf_pkg.sv
// Shared types, constants and Bernstein weight tables for the Bezier curve flattener.
package bcf_pkg;

   localparam int SEGMENTS = 10;
   localparam int K_W      = $clog2(SEGMENTS + 1);
   localparam int W_W      = 17;    // Q1.16, 1.0 = 65536
   localparam int COORD_W  = 16;

   localparam longint unsigned DEN2 = longint'(SEGMENTS) * SEGMENTS;
   localparam longint unsigned DEN3 = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;

   localparam logic FUNC_QUAD  = 1'b0;
   localparam logic FUNC_CUBIC = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [3:0] coord4_type;
   typedef logic [W_W-1:0] weight_type;
   typedef weight_type [3:0] wrow_type;
   typedef wrow_type [SEGMENTS:0] wtab_type;

   typedef struct packed {
      logic       func;
      coord4_type px;
      coord4_type py;
   } curve_type;

   // Rounded Q1.16 weights for every t = k/SEGMENTS; unused points weigh zero.
   function automatic wtab_type build_wtab(input logic cubic);
      wtab_type          t;
      longint unsigned   num;
      longint unsigned   val;
      int                deg;
      deg = cubic ? 3 : 2;
      for (int k = 0; k <= SEGMENTS; k++) begin
         for (int i = 0; i < 4; i++) begin
            if (i > deg) begin
               t[k][i] = '0;
            end else begin
               num = 1;
               for (int j = 0; j < deg - i; j++) num = num * longint'(SEGMENTS - k);
               for (int j = 0; j < i; j++) num = num * longint'(k);
               if (i != 0 && i != deg) num = num * longint'(deg);
               if (cubic) val = (num * 65536 + DEN3 / 2) / DEN3;
               else       val = (num * 65536 + DEN2 / 2) / DEN2;
               t[k][i] = val[W_W-1:0];
            end
         end
      end
      return t;
   endfunction

   localparam wtab_type W_QUAD  = build_wtab(FUNC_QUAD);
   localparam wtab_type W_CUBIC = build_wtab(FUNC_CUBIC);

endpackage

FILE: rtl/core/bcf_eval.sv
// Three-stage evaluator of one curve coordinate: multiply, sum, round and saturate.
module bcf_eval (
   input  logic                clock,
   input  logic                en,
   input  bcf_pkg::coord4_type pts,
   input  bcf_pkg::wrow_type   wts,
   output bcf_pkg::coord_type  coord
);

   localparam int P_W = bcf_pkg::COORD_W + bcf_pkg::W_W + 1;
   localparam int S_W = P_W + 2;
   localparam int Q_W = S_W - 16;

   logic signed [P_W-1:0] prod_ff [4];
   logic signed [P_W-1:0] prod_in [4];
   logic signed [S_W-1:0] sum_ff, sum_in;
   logic signed [S_W-1:0] rnd;
   logic signed [Q_W-1:0] q;
   bcf_pkg::coord_type    coord_ff, coord_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = P_W'($signed(pts[i]) * $signed({1'b0, wts[i]}));
      end
      sum_in = S_W'(prod_ff[0]) + S_W'(prod_ff[1]) + S_W'(prod_ff[2]) + S_W'(prod_ff[3]);
      rnd = sum_ff + S_W'(32768);
      q   = rnd[S_W-1:16];
      if (q > Q_W'(32767)) begin
         coord_in = 16'sh7fff;
      end else if (q < -Q_W'(32768)) begin
         coord_in = 16'sh8000;
      end else begin
         coord_in = q[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         sum_ff   <= sum_in;
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

FILE: rtl/core/bezier_curve_flattener_core.sv
// Bezier curve flattener top level: curve holding register, segment issue and pipeline.
//
//   channel   direction   ports                             word
//   req       in          req_valid/req_stall, req_func..   one curve, four control points
//   rsp       out         rsp_valid/rsp_stall, rsp_seg_*    one line segment, rsp_last on final
//
// One segment is issued per cycle while the result word is not stalled; the issue
// counter sets the rate. A new curve is taken in the cycle its last segment issues.
// rsp_valid follows an accepted curve through the curve holding register and then the
// weight select, multiply, sum and round/saturate register stages.
// Synchronous reset clears busy, the segment counter and all valid bits.
// A stalled result word freezes every stage, the issue counter included.
module bezier_curve_flattener_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [0:0]  req_func,
   input  logic signed [15:0] req_a_x,
   input  logic signed [15:0] req_a_y,
   input  logic signed [15:0] req_b_x,
   input  logic signed [15:0] req_b_y,
   input  logic signed [15:0] req_c_x,
   input  logic signed [15:0] req_c_y,
   input  logic signed [15:0] req_d_x,
   input  logic signed [15:0] req_d_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_seg_start_x,
   output logic signed [15:0] rsp_seg_start_y,
   output logic signed [15:0] rsp_seg_end_x,
   output logic signed [15:0] rsp_seg_end_y,
   output logic [0:0]  rsp_last
);

   localparam int KW = bcf_pkg::K_W;

   bcf_pkg::curve_type curve_ff, curve_in;
   logic               busy_ff, busy_in;
   logic [KW-1:0]      k_ff, k_in, k_next;
   logic               k_is_last;
   logic               advance, fire, req_ok;

   bcf_pkg::wrow_type  ws_in, we_in, ws_ff, we_ff;
   bcf_pkg::coord4_type px1_ff, py1_ff;
   logic [3:0]         v_ff, v_in;
   logic [3:0]         l_ff, l_in;

   assign advance   = !(v_ff[3] && rsp_stall);
   assign fire      = busy_ff && advance;
   assign k_is_last = (k_ff == KW'(bcf_pkg::SEGMENTS - 1));
   assign k_next    = k_ff + KW'(1);
   assign req_stall = busy_ff && !(fire && k_is_last);
   assign req_ok    = req_valid && !req_stall;

   always_comb begin
      curve_in = curve_ff;
      busy_in  = busy_ff;
      k_in     = k_ff;
      if (fire) begin
         k_in = k_next;
         if (k_is_last) begin
            busy_in = 1'b0;
            k_in    = '0;
         end
      end
      if (req_ok) begin
         curve_in.func  = req_func[0];
         curve_in.px    = {req_d_x, req_c_x, req_b_x, req_a_x};
         curve_in.py    = {req_d_y, req_c_y, req_b_y, req_a_y};
         busy_in        = 1'b1;
         k_in           = '0;
      end
      if (curve_ff.func == bcf_pkg::FUNC_CUBIC) begin
         ws_in = bcf_pkg::W_CUBIC[k_ff];
         we_in = bcf_pkg::W_CUBIC[k_next];
      end else begin
         ws_in = bcf_pkg::W_QUAD[k_ff];
         we_in = bcf_pkg::W_QUAD[k_next];
      end
      v_in = {v_ff[2:0], fire};
      l_in = {l_ff[2:0], k_is_last};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
         v_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
         if (advance) v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      curve_ff <= curve_in;
      if (advance) begin
         ws_ff  <= ws_in;
         we_ff  <= we_in;
         px1_ff <= curve_ff.px;
         py1_ff <= curve_ff.py;
         l_ff   <= l_in;
      end
   end

   bcf_eval u_start_x (.clock(clock), .en(advance), .pts(px1_ff), .wts(ws_ff),
                       .coord(rsp_seg_start_x));
   bcf_eval u_start_y (.clock(clock), .en(advance), .pts(py1_ff), .wts(ws_ff),
                       .coord(rsp_seg_start_y));
   bcf_eval u_end_x   (.clock(clock), .en(advance), .pts(px1_ff), .wts(we_ff),
                       .coord(rsp_seg_end_x));
   bcf_eval u_end_y   (.clock(clock), .en(advance), .pts(py1_ff), .wts(we_ff),
                       .coord(rsp_seg_end_y));

   assign rsp_valid   = v_ff[3];
   assign rsp_last[0] = l_ff[3];

endmodule

FILE: rtl/core/bcf_checker.sv
// Port-level checker for the Bezier curve flattener, bound to the top level.
module bcf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic signed [15:0] rsp_seg_start_x,
   input logic signed [15:0] rsp_seg_start_y,
   input logic signed [15:0] rsp_seg_end_x,
   input logic signed [15:0] rsp_seg_end_y,
   input logic [0:0]  rsp_last
);

   logic        cont_ff;
   logic signed [15:0] end_x_ff, end_y_ff;
   logic        rsp_ok;

   assign rsp_ok = rsp_valid && !rsp_stall;

   // remember where the last delivered segment ended, within one curve
   always_ff @(posedge clock) begin
      if (reset) begin
         cont_ff <= 1'b0;
      end else if (rsp_ok) begin
         cont_ff <= !rsp_last[0];
      end
      if (rsp_ok) begin
         end_x_ff <= rsp_seg_end_x;
         end_y_ff <= rsp_seg_end_y;
      end
   end

   a_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cont_ff |-> rsp_seg_start_x == end_x_ff && rsp_seg_start_y == end_y_ff)
      else $error("segment does not start where the previous one ended");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (bcf_pkg::SEGMENTS > 1) && req_valid && !req_stall |=> req_stall)
      else $error("new curve taken while segments remain");

   a_rst: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_seg_end_x) && $stable(rsp_last))
      else $error("stalled result word dropped or changed");

endmodule

bind bezier_curve_flattener_core bcf_checker u_bcf_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_seg_start_x(rsp_seg_start_x), .rsp_seg_start_y(rsp_seg_start_y),
   .rsp_seg_end_x(rsp_seg_end_x), .rsp_seg_end_y(rsp_seg_end_y),
   .rsp_last(rsp_last)
);

FILE: tb/bcf_segment_checker.sv
// Segment checker: predicts the line segments of each accepted curve and compares them.
`timescale 1ns / 1ps

module bcf_segment_checker
   import bcf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [0:0]  req_func,
   input  coord_type   req_a_x,
   input  coord_type   req_a_y,
   input  coord_type   req_b_x,
   input  coord_type   req_b_y,
   input  coord_type   req_c_x,
   input  coord_type   req_c_y,
   input  coord_type   req_d_x,
   input  coord_type   req_d_y,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  coord_type   rsp_seg_start_x,
   input  coord_type   rsp_seg_start_y,
   input  coord_type   rsp_seg_end_x,
   input  coord_type   rsp_seg_end_y,
   input  logic [0:0]  rsp_last,
   output int          mismatch_count,
   output int          segments_owed
);

   typedef struct packed {
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
      logic      last;
   } segment_type;

   segment_type owed_segments[$];
   coord4_type  req_px;
   coord4_type  req_py;

   assign req_px = {req_d_x, req_c_x, req_b_x, req_a_x};
   assign req_py = {req_d_y, req_c_y, req_b_y, req_a_y};

   // Q1.16 Bernstein weight of point i at t = k/SEGMENTS, rounded half up
   function automatic longint unsigned bernstein_q16(int deg, int i, int k);
      longint unsigned num;
      longint unsigned den;
      num = 1;
      den = 1;
      for (int j = 0; j < deg; j++) den = den * SEGMENTS;
      for (int j = 0; j < deg - i; j++) num = num * longint'(SEGMENTS - k);
      for (int j = 0; j < i; j++) num = num * longint'(k);
      if (i != 0 && i != deg) num = num * longint'(deg);
      return (num * 65536 + den / 2) / den;
   endfunction

   function automatic coord_type curve_coord(logic cubic, coord4_type p, int k);
      longint acc;
      longint q;
      int     deg;
      acc = 0;
      deg = (cubic == FUNC_CUBIC) ? 3 : 2;
      for (int i = 0; i <= deg; i++)
         acc += longint'($signed(p[i])) * longint'(bernstein_q16(deg, i, k));
      q = (acc + 32768) >>> 16;   // floor, ties go up
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return coord_type'(q[15:0]);
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      segment_type want;
      if (reset) begin
         mismatch_count = 0;
         segments_owed  = 0;
      end else begin
         if (req_valid && !req_stall) begin
            for (int k = 0; k < SEGMENTS; k++) begin
               want.sx   = curve_coord(req_func, req_px, k);
               want.sy   = curve_coord(req_func, req_py, k);
               want.ex   = curve_coord(req_func, req_px, k + 1);
               want.ey   = curve_coord(req_func, req_py, k + 1);
               want.last = (k == SEGMENTS - 1);
               owed_segments = {owed_segments, want};
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_segments.size() == 0) begin
               mismatch_count++;
               $display("%0t: segment word with none expected, got (%0d,%0d)-(%0d,%0d)",
                        $time, rsp_seg_start_x, rsp_seg_start_y, rsp_seg_end_x,
                        rsp_seg_end_y);
            end else begin
               want = owed_segments.pop_front();
               check_field("seg_start_x", want.sx, rsp_seg_start_x);
               check_field("seg_start_y", want.sy, rsp_seg_start_y);
               check_field("seg_end_x", want.ex, rsp_seg_end_x);
               check_field("seg_end_y", want.ey, rsp_seg_end_y);
               check_field("last", want.last, rsp_last);
            end
         end
         segments_owed = owed_segments.size();
      end
   end

endmodule

FILE: tb/tb_bezier_curve_flattener_core.sv
// Testbench top: clock, reset, curve stimulus, receiver back-pressure and verdict.
`timescale 1ns / 1ps

module tb_bezier_curve_flattener_core;
   import bcf_pkg::*;

   localparam coord_type CMAX       = 16'sh7FFF;
   localparam coord_type CMIN       = 16'sh8000;
   localparam int        IDLE_PCT   = 37;
   localparam int        HOLD_LEN   = 80;
   localparam int        DRAIN_WAIT = 30;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_valid  = 1'b0;
   logic       req_stall;
   logic [0:0] req_func   = FUNC_QUAD;
   coord_type  req_a_x    = '0;
   coord_type  req_a_y    = '0;
   coord_type  req_b_x    = '0;
   coord_type  req_b_y    = '0;
   coord_type  req_c_x    = '0;
   coord_type  req_c_y    = '0;
   coord_type  req_d_x    = '0;
   coord_type  req_d_y    = '0;
   logic       rsp_valid;
   logic       rsp_stall  = 1'b0;
   coord_type  rsp_seg_start_x;
   coord_type  rsp_seg_start_y;
   coord_type  rsp_seg_end_x;
   coord_type  rsp_seg_end_y;
   logic [0:0] rsp_last;

   int         mismatch_count;
   int         segments_owed;
   int         hold_requests = 0;
   logic       rsp_quiet  = 1'b0;

   bezier_curve_flattener_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_b_x(req_b_x), .req_b_y(req_b_y),
      .req_c_x(req_c_x), .req_c_y(req_c_y), .req_d_x(req_d_x), .req_d_y(req_d_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_seg_start_x(rsp_seg_start_x), .rsp_seg_start_y(rsp_seg_start_y),
      .rsp_seg_end_x(rsp_seg_end_x), .rsp_seg_end_y(rsp_seg_end_y),
      .rsp_last(rsp_last)
   );

   bcf_segment_checker u_seg_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_b_x(req_b_x), .req_b_y(req_b_y),
      .req_c_x(req_c_x), .req_c_y(req_c_y), .req_d_x(req_d_x), .req_d_y(req_d_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_seg_start_x(rsp_seg_start_x), .rsp_seg_start_y(rsp_seg_start_y),
      .rsp_seg_end_x(rsp_seg_end_x), .rsp_seg_end_y(rsp_seg_end_y),
      .rsp_last(rsp_last),
      .mismatch_count(mismatch_count), .segments_owed(segments_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400000;
      $display("FAIL");
      $finish;
   end

   // receiver: random stalls, a quiet stretch, and one long hold-off on request
   initial begin
      int holds_done;
      holds_done = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_requests > holds_done) begin
            rsp_stall <= 1'b1;
            for (int n = 0; n < HOLD_LEN; n++) @(posedge clock);
            holds_done++;
         end else begin
            rsp_stall <= !rsp_quiet && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // holds the word until the block takes it; returns at the accepting edge
   task automatic offer_curve(logic func, coord4_type px, coord4_type py);
      req_valid <= 1'b1;
      req_func  <= func;
      req_a_x <= px[0]; req_b_x <= px[1]; req_c_x <= px[2]; req_d_x <= px[3];
      req_a_y <= py[0]; req_b_y <= py[1]; req_c_y <= py[2]; req_d_y <= py[3];
      do @(posedge clock); while (req_stall);
   endtask

   task automatic sender_gap(bit allow);
      int gap;
      gap = (allow && $urandom_range(99) < IDLE_PCT) ? $urandom_range(4, 46) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 9))
         0:       return CMAX;
         1:       return CMIN;
         2:       return coord_type'(int'($urandom_range(0, 64)) - 32);
         3:       return coord_type'(32767 - int'($urandom_range(0, 15)));
         4:       return coord_type'(-32768 + int'($urandom_range(0, 15)));
         default: return coord_type'($urandom());
      endcase
   endfunction

   task automatic random_curve(bit allow_gap);
      coord4_type px;
      coord4_type py;
      for (int i = 0; i < 4; i++) begin
         px[i] = pick_coord();
         py[i] = pick_coord();
      end
      offer_curve($urandom_range(0, 1) ? FUNC_CUBIC : FUNC_QUAD, px, py);
      sender_gap(allow_gap);
   endtask

   initial begin
      coord4_type d_px[$];
      coord4_type d_py[$];
      logic       d_fn[$];
      coord4_type alt;
      coord4_type ramp;

      alt  = {CMIN, CMAX, CMIN, CMAX};
      ramp = {CMAX, coord_type'(16'sh2000), coord_type'(-16'sh2000), CMIN};

      // directed: zeros, full-scale corners, alternating hulls, ramps, LSB values
      d_fn = '{FUNC_QUAD, FUNC_CUBIC, FUNC_QUAD, FUNC_CUBIC, FUNC_QUAD, FUNC_CUBIC,
               FUNC_QUAD, FUNC_CUBIC, FUNC_QUAD, FUNC_CUBIC, FUNC_QUAD, FUNC_CUBIC,
               FUNC_QUAD, FUNC_CUBIC, FUNC_QUAD, FUNC_CUBIC};
      d_px = '{'0, '0, {4{CMAX}}, {4{CMAX}}, {4{CMIN}}, {4{CMIN}},
               alt, alt, ~alt, ~alt, ramp, ramp,
               {4{16'sh0001}}, {4{16'shFFFF}}, {CMIN, CMIN, CMAX, CMAX}, {4{CMAX}}};
      d_py = '{'0, '0, {4{CMAX}}, {4{CMAX}}, {4{CMIN}}, {4{CMIN}},
               ~alt, ~alt, alt, alt, ~ramp, ~ramp,
               {4{16'shFFFF}}, {4{16'sh0001}}, {CMAX, CMAX, CMIN, CMIN}, {4{CMIN}}};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < d_fn.size(); n++) begin
         offer_curve(d_fn[n], d_px[n], d_py[n]);
         sender_gap(1'b1);
      end

      // sender waits for the pipeline to drain completely
      req_valid <= 1'b0;
      @(posedge clock);
      wait (segments_owed == 0);
      @(posedge clock);

      // long receiver hold-off with the sender pushing back to back
      hold_requests++;
      repeat (15) random_curve(1'b0);

      // no idling on either side
      rsp_quiet = 1'b1;
      repeat (30) random_curve(1'b0);
      rsp_quiet = 1'b0;

      repeat (150) random_curve(1'b1);

      req_valid <= 1'b0;
      @(posedge clock);
      wait (segments_owed == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && segments_owed == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
